// ===== hdl/line_point_interpolator_unit_macros.svh =====
// Assertion macros shared by the line point interpolator RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef LINE_POINT_INTERPOLATOR_UNIT_MACROS_SVH
`define LINE_POINT_INTERPOLATOR_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define LPI_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lpi same-cycle check failed");

// next-cycle implication, checked outside reset
`define LPI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lpi next-cycle check failed");

`endif

// ===== hdl/lpi_pkg.sv =====
// Package for the line point interpolator: fixed widths, curve codes and
// ease table constants. No dependencies.
package lpi_pkg;

   localparam int STEP_BITS    = 13;
   localparam int EASE_BITS    = 16;
   localparam int TAYLOR_TERMS = 8;
   localparam longint unsigned PI_Q30 = 64'd3373259426;

   typedef enum logic {
      CURVE_LINEAR = 1'b0,
      CURVE_SMOOTH = 1'b1
   } curve_mode_type;

endpackage

// ===== hdl/line_point_interpolator_unit.sv =====
// Line point interpolator top level: pipelined span, divide, ease and add.
// Depends on lpi_pkg and line_point_interpolator_unit_macros.svh.
//
// Usage:
//  req channel carries two endpoints and a step index; rsp channel returns the
//  pixel at that step, with tuser set when the step lies past the major span
//  (pixel then reads 0). csr_wr_en/csr_wr_data set the curve mode (0 linear,
//  1 cosine eased); write it only while the pipe is empty.
//  Throughput: one transfer per cycle while no stall holds the pipe. Path: stages 0-2,
//  the QUO_BITS divider stages, then stages 3-5 (stage 5 is the output register),
//  where QUO_BITS = max(COORD_BITS, log2(EASE_TABLE_DEPTH)+1); it is set by the
//  restoring divider, which resolves one quotient bit per stage.
//  The ease table is a constant ROM read in its own registered stage.
//  Stall: when rsp_tready is low with a result waiting, every stage holds and
//  req_tready drops; nothing is lost or repeated.
//  Reset: synchronous, clears all valid bits and sets linear mode.
//  EASE_TABLE_DEPTH must be a power of two.
module line_point_interpolator_unit #(
   parameter int COORD_BITS       = 13,
   parameter int EASE_TABLE_DEPTH = 1024
) (
   input  logic clock,
   input  logic reset,
   // configuration
   input  logic csr_wr_en,
   input  logic csr_wr_data,
   // request stream
   input  logic req_tvalid,
   output logic req_tready,
   // [x_start, y_start, x_end, y_end, step_index] low bits first, zero padded
   input  logic [((4*COORD_BITS+lpi_pkg::STEP_BITS+7)/8)*8-1:0] req_tdata,
   // response stream
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // [pixel_x, pixel_y] low bits first, zero padded
   output logic [((2*COORD_BITS+7)/8)*8-1:0] rsp_tdata,
   // [step_beyond_span]
   output logic rsp_tuser
);

   localparam int CB       = COORD_BITS;
   localparam int SB       = lpi_pkg::STEP_BITS;
   localparam int EB       = lpi_pkg::EASE_BITS;
   localparam int LD       = $clog2(EASE_TABLE_DEPTH);
   localparam int QUO_BITS = (CB > LD + 1) ? CB : LD + 1;
   localparam int NB       = SB + QUO_BITS;
   localparam int CW       = NB + CB;
   localparam int RSP_W    = ((2*CB+7)/8)*8;

   // Taylor divisors (2n)(2n+1) as rounded-up Q64 reciprocals
   localparam logic [63:0] TAYLOR_RECIP [1:lpi_pkg::TAYLOR_TERMS] = '{
      64'hFFFF_FFFF_FFFF_FFFF / 64'd6   + 64'd1,
      64'hFFFF_FFFF_FFFF_FFFF / 64'd20  + 64'd1,
      64'hFFFF_FFFF_FFFF_FFFF / 64'd42  + 64'd1,
      64'hFFFF_FFFF_FFFF_FFFF / 64'd72  + 64'd1,
      64'hFFFF_FFFF_FFFF_FFFF / 64'd110 + 64'd1,
      64'hFFFF_FFFF_FFFF_FFFF / 64'd156 + 64'd1,
      64'hFFFF_FFFF_FFFF_FFFF / 64'd210 + 64'd1,
      64'hFFFF_FFFF_FFFF_FFFF / 64'd272 + 64'd1
   };

   typedef logic [EB-1:0] ease_rom_type [EASE_TABLE_DEPTH];

   // per-item context carried down the pipe
   typedef struct packed {
      logic [CB-1:0] x0;
      logic [CB-1:0] y0;
      logic          xpos;
      logic          ypos;
      logic [SB-1:0] step;
      logic [CB-1:0] minor;
      logic [CB-1:0] major;
      logic          x_minor;
      logic          equal;
      logic          beyond;
      lpi_pkg::curve_mode_type mode;
   } ctx_type;

   // ease table: sin^2 of pi*k/(2*depth), Q0.16
   function automatic ease_rom_type build_ease_rom();
      ease_rom_type    rom;
      longint unsigned b;
      longint unsigned term;
      longint unsigned s;
      longint unsigned h;
      logic [127:0]    wide;
      for (int k = 0; k < EASE_TABLE_DEPTH; k++) begin
         b = (longint'(k) * lpi_pkg::PI_Q30) >> (LD + 1);
         term = b;
         s = b;
         for (int n = 1; n <= lpi_pkg::TAYLOR_TERMS; n++) begin
            term = (term * b) >> 30;
            term = (term * b) >> 30;
            wide = 128'(term) * 128'(TAYLOR_RECIP[n]);
            term = wide[127:64];
            if ((n & 1) == 1) begin
               s = s - term;
            end else begin
               s = s + term;
            end
         end
         h = (s * s + (64'd1 << 43)) >> 44;
         if (h > 64'd65535) begin
            h = 64'd65535;
         end
         rom[k] = h[EB-1:0];
      end
      return rom;
   endfunction

   localparam ease_rom_type EASE_ROM = build_ease_rom();

   // global advance: whole pipe moves unless a result is stuck at the output
   logic adv;
   logic out_valid_ff;
   assign adv        = !out_valid_ff || rsp_tready;
   assign req_tready = adv;

   // curve mode register
   lpi_pkg::curve_mode_type mode_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= lpi_pkg::CURVE_LINEAR;
      end else if (csr_wr_en) begin
         mode_ff <= lpi_pkg::curve_mode_type'(csr_wr_data);
      end
   end

   // stage 0: capture request
   logic          s0_valid_ff;
   logic [CB-1:0] s0_x0_ff, s0_y0_ff, s0_x1_ff, s0_y1_ff;
   logic [SB-1:0] s0_step_ff;
   lpi_pkg::curve_mode_type s0_mode_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (adv) begin
         s0_valid_ff <= req_tvalid;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s0_x0_ff   <= req_tdata[CB-1:0];
         s0_y0_ff   <= req_tdata[2*CB-1:CB];
         s0_x1_ff   <= req_tdata[3*CB-1:2*CB];
         s0_y1_ff   <= req_tdata[4*CB-1:3*CB];
         s0_step_ff <= req_tdata[4*CB+SB-1:4*CB];
         s0_mode_ff <= mode_ff;
      end
   end

   // stage 1: spans, directions, major/minor selection
   logic          xpos, ypos;
   logic [CB-1:0] dx, dy;
   ctx_type       s1_in;
   ctx_type       s1_ff;
   logic          s1_valid_ff;
   always_comb begin
      xpos = $signed(s0_x1_ff) > $signed(s0_x0_ff);
      ypos = $signed(s0_y1_ff) > $signed(s0_y0_ff);
      dx   = xpos ? s0_x1_ff - s0_x0_ff : s0_x0_ff - s0_x1_ff;
      dy   = ypos ? s0_y1_ff - s0_y0_ff : s0_y0_ff - s0_y1_ff;
      s1_in.x0      = s0_x0_ff;
      s1_in.y0      = s0_y0_ff;
      s1_in.xpos    = xpos;
      s1_in.ypos    = ypos;
      s1_in.step    = s0_step_ff;
      s1_in.x_minor = dx < dy;
      s1_in.equal   = dx == dy;
      s1_in.major   = (dx > dy) ? dx : dy;
      s1_in.minor   = (dx > dy) ? dy : dx;
      s1_in.beyond  = {{(CB > SB ? CB - SB : 0) + 1{1'b0}}, s0_step_ff} >
                      {{(SB > CB ? SB - CB : 0) + 1{1'b0}}, s1_in.major};
      s1_in.mode    = s0_mode_ff;
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= s0_valid_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff <= s1_in;
      end
   end

   // stage 2: dividend, step*minor (linear) or step*depth (smooth)
   logic [NB-1:0] num_in;
   logic [NB-1:0] s2_num_ff;
   ctx_type       s2_ff;
   logic          s2_valid_ff;
   always_comb begin
      if (s1_ff.mode == lpi_pkg::CURVE_LINEAR) begin
         num_in = NB'(s1_ff.step) * NB'(s1_ff.minor);
      end else begin
         num_in = NB'({s1_ff.step, {LD{1'b0}}});
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s2_ff     <= s1_ff;
         s2_num_ff <= num_in;
      end
   end

   // divider: one restoring quotient bit per stage, MSB first
   logic          dv_valid_ff [1:QUO_BITS];
   ctx_type       dv_ctx_ff   [1:QUO_BITS];
   logic [NB-1:0] dv_rem_ff   [1:QUO_BITS];
   logic [QUO_BITS-1:0] dv_quo_ff [1:QUO_BITS];

   for (genvar i = 0; i < QUO_BITS; i++) begin : g_div
      localparam int BIT = QUO_BITS - 1 - i;
      logic                cur_valid;
      ctx_type             cur_ctx;
      logic [NB-1:0]       cur_rem;
      logic [QUO_BITS-1:0] cur_quo;
      logic [CW-1:0]       dsr;
      logic                take;
      logic [NB-1:0]       rem_in;
      logic [QUO_BITS-1:0] quo_in;
      // first stage takes the dividend stage, later ones the previous bit
      if (i == 0) begin : g_first
         assign cur_valid = s2_valid_ff;
         assign cur_ctx   = s2_ff;
         assign cur_rem   = s2_num_ff;
         assign cur_quo   = '0;
      end else begin : g_next
         assign cur_valid = dv_valid_ff[i];
         assign cur_ctx   = dv_ctx_ff[i];
         assign cur_rem   = dv_rem_ff[i];
         assign cur_quo   = dv_quo_ff[i];
      end
      always_comb begin
         dsr    = CW'(cur_ctx.major) << BIT;
         take   = CW'(cur_rem) >= dsr;
         rem_in = take ? NB'(CW'(cur_rem) - dsr) : cur_rem;
         quo_in = cur_quo;
         quo_in[BIT] = take;
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[i+1] <= 1'b0;
         end else if (adv) begin
            dv_valid_ff[i+1] <= cur_valid;
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            dv_ctx_ff[i+1] <= cur_ctx;
            dv_rem_ff[i+1] <= rem_in;
            dv_quo_ff[i+1] <= quo_in;
         end
      end
   end

   // stage 3: ease table read, full-span detection
   ctx_type             s3_ff;
   logic                s3_valid_ff;
   logic [QUO_BITS-1:0] s3_quo_ff;
   logic [EB-1:0]       s3_ease_ff;
   logic                s3_full_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= dv_valid_ff[QUO_BITS];
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s3_ff      <= dv_ctx_ff[QUO_BITS];
         s3_quo_ff  <= dv_quo_ff[QUO_BITS];
         s3_ease_ff <= EASE_ROM[dv_quo_ff[QUO_BITS][LD-1:0]];
         s3_full_ff <= (dv_quo_ff[QUO_BITS] >> LD) != '0;
      end
   end

   // stage 4: minor offset
   logic [CB-1:0]    moff_in;
   logic [CB+EB-1:0] prod;
   ctx_type          s4_ff;
   logic             s4_valid_ff;
   logic [CB-1:0]    s4_moff_ff;
   always_comb begin
      prod = s3_ff.minor * s3_ease_ff;
      if (s3_ff.mode == lpi_pkg::CURVE_LINEAR) begin
         moff_in = s3_quo_ff[CB-1:0];
      end else if (s3_full_ff) begin
         moff_in = s3_ff.minor;
      end else begin
         moff_in = prod[CB+EB-1:EB];
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (adv) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s4_ff      <= s3_ff;
         s4_moff_ff <= moff_in;
      end
   end

   // stage 5: apply offsets, output register
   logic [CB-1:0] step_c, offx, offy, px_in, py_in;
   logic [CB-1:0] out_px_ff, out_py_ff;
   logic          out_beyond_ff;
   always_comb begin
      step_c = CB'(s4_ff.step);
      offx   = step_c;
      offy   = step_c;
      if (!s4_ff.equal) begin
         if (s4_ff.x_minor) begin
            offx = s4_moff_ff;
         end else begin
            offy = s4_moff_ff;
         end
      end
      px_in = s4_ff.xpos ? s4_ff.x0 + offx : s4_ff.x0 - offx;
      py_in = s4_ff.ypos ? s4_ff.y0 + offy : s4_ff.y0 - offy;
      if (s4_ff.beyond) begin
         px_in = '0;
         py_in = '0;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= s4_valid_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         out_px_ff     <= px_in;
         out_py_ff     <= py_in;
         out_beyond_ff <= s4_ff.beyond;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_W'({out_py_ff, out_px_ff});
   assign rsp_tuser  = out_beyond_ff;

   // checks
`include "line_point_interpolator_unit_macros.svh"
   `LPI_ASSERT_IMPL(a_beyond_zero, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata == '0)
   `LPI_ASSERT_IMPL(a_ready_rule, clock, reset, 1'b1, req_tready == (!rsp_tvalid || rsp_tready))
   `LPI_ASSERT_NEXT(a_hold_stall, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))

endmodule

// ===== tb/tb_line_point_checker.sv =====
// Checker for the line point interpolator: watches the req and rsp channels,
// predicts each pixel and compares it in order. Depends on lpi_pkg.
module tb_line_point_checker #(
   parameter int COORD_BITS       = 13,
   parameter int EASE_TABLE_DEPTH = 1024,
   parameter int REQ_W            = 72,
   parameter int RSP_W            = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic             csr_wr_data,
   input  logic             req_tvalid,
   input  logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic [RSP_W-1:0] rsp_tdata,
   input  logic             rsp_tuser,
   output int               fail_count,
   output int               pending_pixels,
   output int               pixel_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [COORD_BITS-1:0] px;
      logic [COORD_BITS-1:0] py;
      logic                  beyond;
   } pixel_type;

   longint unsigned          ease_rom [EASE_TABLE_DEPTH];
   lpi_pkg::curve_mode_type  curve_sel;
   pixel_type                expected_pixels [$];

   // ease table entry, sin^2 of pi*k/(2*depth) in Q0.16
   function automatic longint unsigned ease_value(int k);
      longint unsigned b, term, s, h;
      b = (longint'(k) * lpi_pkg::PI_Q30) / (2 * EASE_TABLE_DEPTH);
      term = b;
      s = b;
      for (int n = 1; n <= lpi_pkg::TAYLOR_TERMS; n++) begin
         term = (term * b) >> 30;
         term = (term * b) >> 30;
         term = term / ((2 * n) * (2 * n + 1));
         if (n % 2) s = s - term;
         else s = s + term;
      end
      h = (s * s + (64'd1 << 43)) >> 44;
      if (h > 65535) h = 65535;
      return h;
   endfunction

   function automatic longint minor_shift(longint step, longint minor, longint major);
      longint frac;
      if (curve_sel == lpi_pkg::CURVE_LINEAR) return (step * minor) / major;
      frac = (step * EASE_TABLE_DEPTH) / major;
      if (frac >= EASE_TABLE_DEPTH) return minor;
      return (minor * longint'(ease_rom[frac])) >> 16;
   endfunction

   function automatic pixel_type interpolate_pixel(logic [REQ_W-1:0] d);
      pixel_type r;
      longint x0, y0, x1, y1, step, dx, dy, major, ox, oy;
      x0 = $signed(d[COORD_BITS-1:0]);
      y0 = $signed(d[2*COORD_BITS-1:COORD_BITS]);
      x1 = $signed(d[3*COORD_BITS-1:2*COORD_BITS]);
      y1 = $signed(d[4*COORD_BITS-1:3*COORD_BITS]);
      step = d[4*COORD_BITS +: lpi_pkg::STEP_BITS];
      dx = x1 > x0 ? x1 - x0 : x0 - x1;
      dy = y1 > y0 ? y1 - y0 : y0 - y1;
      major = dx > dy ? dx : dy;
      r = '0;
      if (step > major) begin
         r.beyond = 1'b1;
         return r;
      end
      ox = step;
      oy = step;
      if (dx < dy) ox = minor_shift(step, dx, dy);
      else if (dy < dx) oy = minor_shift(step, dy, dx);
      r.px = COORD_BITS'(x1 > x0 ? x0 + ox : x0 - ox);
      r.py = COORD_BITS'(y1 > y0 ? y0 + oy : y0 - oy);
      return r;
   endfunction

   initial begin
      for (int k = 0; k < EASE_TABLE_DEPTH; k++) ease_rom[k] = ease_value(k);
   end

   assign pending_pixels = expected_pixels.size();

   // predict on req transfers, compare on rsp transfers
   always @(posedge clock) begin
      pixel_type want, got;
      if (reset) begin
         curve_sel <= lpi_pkg::CURVE_LINEAR;
         fail_count <= 0;
         pixel_count <= 0;
         expected_pixels.delete();
      end else begin
         if (csr_wr_en) curve_sel <= lpi_pkg::curve_mode_type'(csr_wr_data);
         if (rsp_tvalid && rsp_tready) begin
            got.px = rsp_tdata[COORD_BITS-1:0];
            got.py = rsp_tdata[2*COORD_BITS-1:COORD_BITS];
            got.beyond = rsp_tuser;
            pixel_count <= pixel_count + 1;
            if (expected_pixels.size() == 0) begin
               $display("%0t: unexpected pixel x=%0d y=%0d beyond=%0b", $time,
                        $signed(got.px), $signed(got.py), got.beyond);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_pixels.pop_front();
               if (want != got) begin
                  $display("%0t: pixel mismatch expected x=%0d y=%0d beyond=%0b,",
                           $time, $signed(want.px), $signed(want.py), want.beyond,
                           " got x=%0d y=%0d beyond=%0b",
                           $signed(got.px), $signed(got.py), got.beyond);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_tvalid && req_tready) expected_pixels.push_back(interpolate_pixel(req_tdata));
      end
   end
endmodule

// ===== tb/tb_top.sv =====
// Testbench top for line_point_interpolator_unit: drives endpoints and steps,
// stalls both sides and gives the verdict. Depends on lpi_pkg, the unit and the checker.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CB    = 13;
   localparam int SB    = lpi_pkg::STEP_BITS;
   localparam int REQ_W = ((4*CB+SB+7)/8)*8;
   localparam int RSP_W = ((2*CB+7)/8)*8;
   localparam int LATENCY = 18;

   logic             clock, reset;
   logic             csr_wr_en, csr_wr_data;
   logic             req_tvalid, req_tready;
   logic [REQ_W-1:0] req_tdata;
   logic             rsp_tvalid, rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;
   logic             rsp_tuser;
   int               fail_count, pending_pixels, pixel_count;
   int               req_count;
   bit               hold_rsp;

   line_point_interpolator_unit #(.COORD_BITS(CB), .EASE_TABLE_DEPTH(1024)) u_top (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   tb_line_point_checker #(.COORD_BITS(CB), .EASE_TABLE_DEPTH(1024),
                           .REQ_W(REQ_W), .RSP_W(RSP_W)) u_checker (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .fail_count(fail_count),
      .pending_pixels(pending_pixels), .pixel_count(pixel_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("timeout");
      $display("tb_top NOT OK");
      $finish;
   end

   function automatic int gap_len();
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
      if ($urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, 3);
   endfunction

   // one request transfer, with a random gap in front
   task automatic send_line(int x0, int y0, int x1, int y1, int step);
      int gap;
      gap = gap_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= REQ_W'({SB'(step), CB'(y1), CB'(x1), CB'(y0), CB'(x0)});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      req_count++;
   endtask

   task automatic drain_pipe();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_pixels != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_curve(lpi_pkg::curve_mode_type m);
      csr_wr_en <= 1'b1;
      csr_wr_data <= m;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   function automatic int rand_coord();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 8191) - 4096;
         1: return $urandom_range(0, 40) - 20;
         2: return ($urandom_range(0, 1) ? 4095 : -4096) - $urandom_range(0, 3) *
                   ($urandom_range(0, 1) ? 1 : -1) * 0;
         default: return $urandom_range(0, 400) - 200;
      endcase
   endfunction

   // random line, mostly with step inside the span
   task automatic random_line();
      int x0, y0, x1, y1, major, step;
      x0 = rand_coord();
      y0 = rand_coord();
      x1 = rand_coord();
      y1 = rand_coord();
      if ($urandom_range(0, 9) == 0) y1 = y0 + ((x1 > x0) ? x1 - x0 : x0 - x1);
      if (y1 > 4095 || y1 < -4096) y1 = y0;
      major = (x1 > x0 ? x1 - x0 : x0 - x1);
      if ((y1 > y0 ? y1 - y0 : y0 - y1) > major) major = (y1 > y0 ? y1 - y0 : y0 - y1);
      case ($urandom_range(0, 9))
         0: step = $urandom_range(0, 8191);
         1: step = major;
         2: step = (major < 8191) ? major + 1 : major;
         default: step = $urandom_range(0, major);
      endcase
      send_line(x0, y0, x1, y1, step);
   endtask

   // receiver: random stalls, plus a long hold when asked
   initial begin
      int gap;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (200) @(posedge clock);
            hold_rsp = 1'b0;
         end
         gap = gap_len();
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   initial begin
      int lim;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = 1'b0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_count = 0;
      hold_rsp = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, equal spans, single point, both directions, past span
      for (int m = 0; m < 2; m++) begin
         write_curve(lpi_pkg::curve_mode_type'(m));
         send_line(-4096, -4096, 4095, 4095, 8191);
         send_line(-4096, -4096, 4095, 4095, 8190);
         send_line(-4096, 0, 4095, 100, 4000);
         send_line(4095, 4095, -4096, -4096, 0);
         send_line(10, 10, 10, 10, 0);
         send_line(10, 10, 10, 10, 1);
         send_line(0, 0, 50, 50, 25);
         send_line(0, 0, -30, 7, 17);
         send_line(0, 0, 7, -300, 299);
         send_line(0, 0, 0, 300, 150);
         send_line(5, 5, 1005, 700, 1000);
         send_line(-4096, 4095, 4095, -4096, 8191);
         drain_pipe();
      end

      // random phases across both curve modes
      for (int ph = 0; ph < 8; ph++) begin
         write_curve(lpi_pkg::curve_mode_type'(ph % 2));
         if (ph == 3) hold_rsp = 1'b1;
         lim = 200;
         for (int i = 0; i < lim; i++) random_line();
         drain_pipe();
      end

      repeat (LATENCY + 4) @(posedge clock);
      $display("covered %0d lines in linear and eased modes, %0d pixels returned",
               req_count, pixel_count);
      if (fail_count == 0 && pending_pixels == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end
endmodule

// ===== sim.f =====
+incdir+hdl
hdl/lpi_pkg.sv
hdl/line_point_interpolator_unit.sv
tb/tb_line_point_checker.sv
tb/tb_top.sv
